@@ design/lst_pkg.sv @@
// Shared types and constants for the indexed list store.
`timescale 1ns / 1ps

package lst_pkg;

  // Fixed field widths of the request and result items
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int CNT_OUT_W = 5;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    capture;
    logic    insert;
    logic    remove;
    logic    read;
    logic    clear;
    logic    result_valid;
    status_t status;
  } lst_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    req_t req;
    logic pos_gt_count;
    logic pos_ge_count;
    logic full;
  } lst_sts_t;

endpackage

@@ design/lst_ctrl.sv @@
// Controller for the indexed list store: request sequencing and decode.
`timescale 1ns / 1ps

module lst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lst_pkg::lst_sts_t sts,
  output lst_pkg::lst_cmd_t cmd
);
  import lst_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs: capture in idle, decode and execute the held request
  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.capture = start;
      end
      ST_EXEC: begin
        busy             = 1'b1;
        cmd.result_valid = 1'b1;
        cmd.status       = STATUS_OK;
        unique case (sts.req) inside
          REQ_INSERT: begin
            if (sts.pos_gt_count) begin
              cmd.status = STATUS_RANGE;
            end else if (sts.full) begin
              cmd.status = STATUS_FULL;
            end else begin
              cmd.insert = 1'b1;
            end
          end
          REQ_REMOVE, REQ_READ: begin
            if (sts.pos_ge_count) begin
              cmd.status = STATUS_RANGE;
            end else if (sts.req == REQ_REMOVE) begin
              cmd.remove = 1'b1;
            end else begin
              cmd.read = 1'b1;
            end
          end
          REQ_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: begin
            cmd.status = STATUS_OK;
          end
        endcase
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

@@ design/lst_dp.sv @@
// Datapath for the indexed list store: cell row, count and result registers.
`timescale 1ns / 1ps

module lst_dp #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lst_pkg::lst_cmd_t               cmd,
  output lst_pkg::lst_sts_t               sts,
  input  logic [1:0]                      in_req_type,
  input  logic [lst_pkg::POS_W-1:0]       in_position,
  input  logic signed [lst_pkg::VAL_W-1:0] in_item_value,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic signed [lst_pkg::VAL_W-1:0] out_read_value,
  output logic [lst_pkg::CNT_OUT_W-1:0]   out_element_count
);
  import lst_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IDXW = $clog2(CAPACITY);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  // Held request
  req_t                  req_r;
  logic [POS_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] val_r;

  // List state
  logic [DATA_WIDTH-1:0] cells_r [CAPACITY];
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;

  // Result registers
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [VAL_W-1:0]      out_read_value_r;
  logic [CNT_OUT_W-1:0]  out_count_r;

  logic [CMPW-1:0]       pos_cmp;
  logic [CMPW-1:0]       cnt_cmp;
  logic [63:0]           wr_ext;
  logic [63:0]           rd_ext;
  logic [IDXW-1:0]       rd_idx;

  // Request capture; the value is kept in stored form
  assign wr_ext = 64'(in_item_value);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r <= REQ_READ;
    end else if (cmd.capture) begin
      req_r <= req_t'(in_req_type);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos_r <= in_position;
      val_r <= wr_ext[DATA_WIDTH-1:0];
    end
  end

  // Range and fill checks for the controller
  assign pos_cmp = CMPW'(pos_r);
  assign cnt_cmp = CMPW'(count_r);

  always_comb begin
    sts.req          = req_r;
    sts.pos_gt_count = pos_cmp > cnt_cmp;
    sts.pos_ge_count = pos_cmp >= cnt_cmp;
    sts.full         = count_r == CW'(CAPACITY);
  end

  // Cell row: each cell loads, shifts up, shifts down or holds
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.insert) begin
        if (CMPW'(i) == pos_cmp) begin
          cells_r[i] <= val_r;
        end else if (i > 0 && CMPW'(i) > pos_cmp && CMPW'(i) <= cnt_cmp) begin
          cells_r[i] <= cells_r[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.remove) begin
        if (i + 1 < CAPACITY && CMPW'(i) >= pos_cmp && CMPW'(i + 1) < cnt_cmp) begin
          cells_r[i] <= cells_r[(i + 1 < CAPACITY) ? i + 1 : i];
        end
      end
    end
  end

  // Count update
  always_comb begin
    count_nxt = count_r;
    if (cmd.insert) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.remove) begin
      count_nxt = count_r - CW'(1);
    end else if (cmd.clear) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Read port: sign-extend from the stored width
  assign rd_idx = pos_cmp[IDXW-1:0];
  assign rd_ext = 64'($signed(cells_r[rd_idx]));

  // Result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_valid) begin
      out_status_r     <= cmd.status;
      out_read_value_r <= cmd.read ? rd_ext[VAL_W-1:0] : '0;
      out_count_r      <= CNT_OUT_W'(count_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_read_value    = out_read_value_r;
  assign out_element_count = out_count_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> count_r < CW'(CAPACITY))
    else $error("insert into a full list");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> count_r == '0)
    else $error("clear left entries");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.result_valid && cmd.status != STATUS_OK) |=>
      (out_valid && out_read_value_r == '0 && out_count_r == $past(CNT_OUT_W'(count_r))))
    else $error("failed request changed state or returned data");
`endif

endmodule

@@ design/indexed_list_store.sv @@
// Top level of the indexed list store: ordered list with insert, remove, read and clear.
//
// The edge that accepts an item captures the request,
// and the following cycle decodes it and updates the whole cell row in
// parallel (every cell loads, shifts or holds at once). The result strobe out_valid
// rises the cycle after that, for exactly one cycle, and busy is low again in
// that same cycle; no new item is accepted while busy is high. Results
// cannot be held off. Errors (position out of range, empty or full list)
// leave the list unchanged and report a status code; read_value is zero for
// everything but a successful read.
`timescale 1ns / 1ps

module indexed_list_store #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_req_type,
  input  logic [lst_pkg::POS_W-1:0]        in_position,
  input  logic signed [lst_pkg::VAL_W-1:0] in_item_value,
  output logic                             out_valid,
  output logic [1:0]                       out_status,
  output logic signed [lst_pkg::VAL_W-1:0] out_read_value,
  output logic [lst_pkg::CNT_OUT_W-1:0]    out_element_count
);
  import lst_pkg::*;

  lst_cmd_t cmd;
  lst_sts_t sts;

  // Sequencing and decode
  lst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Cell row, count and results
  lst_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_req_type),
    .in_position       (in_position),
    .in_item_value     (in_item_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_read_value    (out_read_value),
    .out_element_count (out_element_count)
  );

endmodule

@@ sim/indexed_list_store_tb.sv @@
// Self-checking testbench for the indexed list store: directed and random requests.
`timescale 1ns / 1ps

module indexed_list_store_tb;
  import lst_pkg::*;

  localparam int CAP = 16;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 577;

  typedef struct {
    status_t                 status;
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_OUT_W-1:0]    count;
  } list_result_t;

  // Shadow copy of the list; predicts each result and checks the block's output
  class list_tracker;
    logic signed [VAL_W-1:0] cells [CAP];
    int                      entries;
    list_result_t            expected_q [$];
    int unsigned             mismatches;

    function new();
      entries = 0;
      mismatches = 0;
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 40) $display("%0t ns mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Apply an accepted request to the shadow list and queue its result
    function void note_request(req_t kind, logic [POS_W-1:0] pos,
                               logic signed [VAL_W-1:0] value);
      list_result_t r;
      int p;
      p = pos;
      r.status = STATUS_OK;
      r.read_value = '0;
      case (kind)
        REQ_INSERT: begin
          // range test wins over the full test
          if (p > entries) r.status = STATUS_RANGE;
          else if (entries >= CAP) r.status = STATUS_FULL;
          else begin
            for (int i = entries; i > p; i--) cells[i] = cells[i-1];
            cells[p] = value;
            entries++;
          end
        end
        REQ_REMOVE: begin
          if (p >= entries) r.status = STATUS_RANGE;
          else begin
            for (int i = p; i + 1 < entries; i++) cells[i] = cells[i+1];
            entries--;
          end
        end
        REQ_READ: begin
          if (p >= entries) r.status = STATUS_RANGE;
          else r.read_value = cells[p];
        end
        default: entries = 0;
      endcase
      r.count = CNT_OUT_W'(entries);
      expected_q = {expected_q, r};
    endfunction

    task check_result(logic [1:0] st, logic signed [VAL_W-1:0] rv,
                      logic [CNT_OUT_W-1:0] cnt);
      list_result_t e;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      e = expected_q[0];
      expected_q.delete(0);
      if (st !== e.status)
        report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
      if (rv !== e.read_value)
        report_mismatch($sformatf("read_value %0h, expected %0h", rv, e.read_value));
      if (cnt !== e.count)
        report_mismatch($sformatf("element_count %0d, expected %0d", cnt, e.count));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [1:0]              in_req_type;
  logic [POS_W-1:0]        in_position;
  logic signed [VAL_W-1:0] in_item_value;
  logic                    out_valid;
  logic [1:0]              out_status;
  logic signed [VAL_W-1:0] out_read_value;
  logic [CNT_OUT_W-1:0]    out_element_count;

  list_tracker tracker;
  int          idle_pct;
  int          stall_cycles;

  indexed_list_store dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_position       (in_position),
    .in_item_value     (in_item_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_read_value    (out_read_value),
    .out_element_count (out_element_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      tracker.check_result(out_status, out_read_value, out_element_count);
  end

  // Watchdog: too long without an accepted item or a result
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL indexed_list_store");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Hold one item on the input until the block takes it
  task automatic send_request(req_t kind, logic [POS_W-1:0] pos,
                              logic signed [VAL_W-1:0] value);
    start <= 1'b1;
    in_req_type <= kind;
    in_position <= pos;
    in_item_value <= value;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_request(kind, pos, value);
  endtask

  // Random gap of idle cycles ahead of the next item
  task automatic pause_sender();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // mode 0 grows the list toward full, mode 1 drains it, mode 2 mixes
  function automatic req_t pick_kind(int mode);
    int roll;
    roll = $urandom_range(99);
    if (roll < ((mode == 0) ? 1 : 3)) return REQ_CLEAR;
    if (mode == 0) return (roll < 63) ? REQ_INSERT : (roll < 78) ? REQ_REMOVE : REQ_READ;
    if (mode == 1) return (roll < 18) ? REQ_INSERT : (roll < 75) ? REQ_REMOVE : REQ_READ;
    return (roll < 38) ? REQ_INSERT : (roll < 68) ? REQ_REMOVE : REQ_READ;
  endfunction

  // Mostly legal positions with the ends favored; some anywhere in the field
  function automatic logic [POS_W-1:0] pick_position(req_t kind, int total);
    int hi;
    hi = (kind == REQ_INSERT) ? total : total - 1;
    if (kind == REQ_CLEAR || hi < 0 || $urandom_range(9) == 0)
      return POS_W'($urandom_range(31));
    case ($urandom_range(3))
      0: return '0;
      1: return POS_W'(hi);
      default: return POS_W'($urandom_range(hi));
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(15))
      0, 1: return {1'b1, {(VAL_W-1){1'b0}}};
      2, 3: return {1'b0, {(VAL_W-1){1'b1}}};
      4: return '0;
      5: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(int count, int pct);
    int mode;
    req_t kind;
    logic [POS_W-1:0] pos;
    idle_pct = pct;
    mode = 2;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) mode = $urandom_range(2);
      kind = pick_kind(mode);
      pos = pick_position(kind, tracker.entries);
      pause_sender();
      send_request(kind, pos, pick_value());
    end
  endtask

  initial begin
    tracker = new();
    idle_pct = 0;
    start <= 1'b0;
    in_req_type <= REQ_INSERT;
    in_position <= '0;
    in_item_value <= '0;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, ends and middle, out of range, clear
    send_request(REQ_CLEAR, 5'd0, pick_value());
    send_request(REQ_READ, 5'd0, pick_value());
    send_request(REQ_REMOVE, 5'd0, pick_value());
    send_request(REQ_INSERT, 5'd1, 32'sh1234_5678);
    send_request(REQ_INSERT, 5'd0, {1'b1, {(VAL_W-1){1'b0}}});
    send_request(REQ_INSERT, 5'd1, {1'b0, {(VAL_W-1){1'b1}}});
    send_request(REQ_INSERT, 5'd1, -32'sd1);
    send_request(REQ_INSERT, 5'd0, '0);
    for (int i = 0; i < 5; i++) send_request(REQ_READ, POS_W'(i), pick_value());
    send_request(REQ_READ, 5'd31, pick_value());
    send_request(REQ_INSERT, 5'd31, 32'sh0F0F_0F0F);
    send_request(REQ_REMOVE, 5'd4, pick_value());
    send_request(REQ_REMOVE, 5'd3, pick_value());
    send_request(REQ_REMOVE, 5'd0, pick_value());
    send_request(REQ_REMOVE, 5'd1, pick_value());
    send_request(REQ_CLEAR, 5'd16, pick_value());
    send_request(REQ_INSERT, 5'd0, 32'sh5555_5555);
    send_request(REQ_READ, 5'd0, pick_value());
    send_request(REQ_INSERT, 5'd16, 32'shAAAA_AAAA);

    // Random: light sender gaps, then heavy gaps, then back to back
    run_random(PHASE_ITEMS, 10);
    run_random(PHASE_ITEMS, 55);
    run_random(PHASE_ITEMS, 0);
    start <= 1'b0;

    // Drain, then keep the clock running to catch any stray result
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("PASS indexed_list_store");
    end else begin
      $display("FAIL indexed_list_store");
    end
    $finish;
  end

endmodule
